// ===== rtl/core/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types and constants of the lru key/value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  localparam int unsigned KEY_WIDTH = 32;
  localparam int unsigned CFG_WIDTH = 5;
  localparam logic [CFG_WIDTH-1:0] CAPACITY_RESET = 5'd16;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } lkv_mode_e;

  // update command from the control path to the entry store
  typedef struct packed {
    logic touch;      // make the selected entry most recent
    logic load_key;   // write key into the selected entry
    logic load_data;  // write data into the selected entry
    logic alloc;      // mark the selected entry valid, bump occupancy
  } lkv_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/lkv_req_if.sv =====
// ----------------------------------------------------------------------------
// lkv_req_if
// request channel: get or put with key and data
// ----------------------------------------------------------------------------
`default_nettype none

interface lkv_req_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  import lkv_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [KEY_WIDTH-1:0]   key;
  logic signed [DATA_WIDTH-1:0]  data_in;

  modport source (output valid, output mode, output key, output data_in, input ready);
  modport sink   (input valid, input mode, input key, input data_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lkv_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lkv_rsp_if
// response channel: hit flag and looked-up data
// ----------------------------------------------------------------------------
`default_nettype none

interface lkv_rsp_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [DATA_WIDTH-1:0]  data_out;

  modport source (output valid, output hit, output data_out, input ready);
  modport sink   (input valid, input hit, input data_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lkv_lookup.sv =====
// ----------------------------------------------------------------------------
// lkv_lookup
// parallel key match, victim and free slot selection
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_lookup #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AGE_W      = 4,
  parameter int unsigned CNT_W      = 5
) (
  input  logic [ENTRIES-1:0]                valid_i,
  input  logic [lkv_pkg::KEY_WIDTH-1:0]     key_i   [ENTRIES],
  input  logic [DATA_WIDTH-1:0]             data_i  [ENTRIES],
  input  logic [AGE_W-1:0]                  age_i   [ENTRIES],
  input  logic [CNT_W-1:0]                  occ_i,
  input  logic [lkv_pkg::KEY_WIDTH-1:0]     req_key_i,
  output logic [ENTRIES-1:0]                match_o,
  output logic [ENTRIES-1:0]                victim_o,
  output logic [ENTRIES-1:0]                free_o,
  output logic                              hit_o,
  output logic [AGE_W-1:0]                  hit_age_o,
  output logic [DATA_WIDTH-1:0]             hit_data_o
);
  import lkv_pkg::*;

  logic [AGE_W-1:0] oldest_rank;

  // ranks form a permutation of 0..occ-1, so the oldest entry holds occ-1
  assign oldest_rank = AGE_W'(occ_i - CNT_W'(1));

  always_comb begin
    hit_age_o  = '0;
    hit_data_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_o[i]  = valid_i[i] && (key_i[i] == req_key_i);
      victim_o[i] = valid_i[i] && (age_i[i] == oldest_rank);
      hit_age_o   = hit_age_o  | (age_i[i]  & {AGE_W{match_o[i]}});
      hit_data_o  = hit_data_o | (data_i[i] & {DATA_WIDTH{match_o[i]}});
    end
  end

  assign hit_o = |match_o;

  // lowest invalid slot
  assign free_o = ~valid_i & (valid_i + ENTRIES'(1));

endmodule

`default_nettype wire

// ===== rtl/core/lkv_store.sv =====
// ----------------------------------------------------------------------------
// lkv_store
// entry registers: valid, key, data, age rank and occupancy
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_store #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AGE_W      = 4,
  parameter int unsigned CNT_W      = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lkv_pkg::lkv_cmd_t                 cmd_i,
  input  logic [ENTRIES-1:0]                sel_i,
  input  logic [CNT_W-1:0]                  rank_i,
  input  logic [lkv_pkg::KEY_WIDTH-1:0]     key_i,
  input  logic [DATA_WIDTH-1:0]             data_i,
  output logic [ENTRIES-1:0]                valid_o,
  output logic [lkv_pkg::KEY_WIDTH-1:0]     key_o   [ENTRIES],
  output logic [DATA_WIDTH-1:0]             data_o  [ENTRIES],
  output logic [AGE_W-1:0]                  age_o   [ENTRIES],
  output logic [CNT_W-1:0]                  occ_o
);
  import lkv_pkg::*;

  logic [ENTRIES-1:0]    valid_q;
  logic [KEY_WIDTH-1:0]  key_q  [ENTRIES];
  logic [DATA_WIDTH-1:0] data_q [ENTRIES];
  logic [AGE_W-1:0]      age_q  [ENTRIES];
  logic [CNT_W-1:0]      occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else if (cmd_i.touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel_i[i]) begin
          age_q[i] <= '0;
          if (cmd_i.alloc) begin
            valid_q[i] <= 1'b1;
          end
        end else if (valid_q[i] && (CNT_W'(age_q[i]) < rank_i)) begin
          age_q[i] <= age_q[i] + AGE_W'(1);
        end
      end
      if (cmd_i.alloc) begin
        occ_q <= occ_q + CNT_W'(1);
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd_i.touch && sel_i[i]) begin
        if (cmd_i.load_key) begin
          key_q[i] <= key_i;
        end
        if (cmd_i.load_data) begin
          data_q[i] <= data_i;
        end
      end
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign data_o  = data_q;
  assign age_o   = age_q;
  assign occ_o   = occ_q;

endmodule

`default_nettype wire

// ===== rtl/core/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key/value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// usage:
//   req_i  : valid/ready request channel; mode get looks up key, mode put
//            writes key/data_in (insert, update, or evict the oldest entry)
//   rsp_o  : valid/ready response channel; one response per get, none per
//            put; hit=1 with stored data, or hit=0 with data_out all ones
//   cfg_we_i/cfg_wdata_i : capacity write, only while the cache is idle;
//            0 acts as 1, values above ENTRIES act as ENTRIES
//   timing : a request is registered on acceptance, then matched against
//            all entries and applied to the age ranks when it is processed;
//            a get result then goes into the response register, and a
//            stall can hold it in the request register first
//   throughput : one request per cycle unless a get waits on a held
//            response; all ENTRIES keys and ranks handled in parallel
//   reset  : all entries invalid, occupancy zero, capacity 16
//   stall  : while a get response waits, the next request is still taken
//            into the request register; a following get holds there until
//            the response register frees, puts pass through regardless
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lkv_pkg::CFG_WIDTH-1:0]  cfg_wdata_i,
  lkv_req_if.sink                        req_i,
  lkv_rsp_if.source                      rsp_o
);
  import lkv_pkg::*;

  localparam int unsigned AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_WIDTH) ? CNT_W : CFG_WIDTH;

  // capacity register
  logic [CFG_WIDTH-1:0] cap_q;
  logic [CMP_W-1:0]     cap_ext;
  logic [CMP_W-1:0]     cap_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPACITY_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign cap_ext = CMP_W'(cap_q);

  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // request register
  logic                  req_valid_q;
  logic                  req_mode_q;
  logic [KEY_WIDTH-1:0]  req_key_q;
  logic [DATA_WIDTH-1:0] req_data_q;
  logic                  req_take;
  logic                  proc_fire;
  logic                  is_put;

  // response register
  logic                  rsp_valid_q;
  logic                  rsp_hit_q;
  logic [DATA_WIDTH-1:0] rsp_data_q;

  assign is_put    = (req_mode_q == MODE_PUT);
  // a put never needs the response register
  assign proc_fire = req_valid_q && (is_put || !rsp_valid_q || rsp_o.ready);
  assign req_take  = req_i.valid && req_i.ready;
  assign req_i.ready = !req_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_mode_q <= req_i.mode;
      req_key_q  <= req_i.key;
      req_data_q <= req_i.data_in;
    end
  end

  // entry store and lookup
  logic [ENTRIES-1:0]    entry_valid;
  logic [KEY_WIDTH-1:0]  entry_key  [ENTRIES];
  logic [DATA_WIDTH-1:0] entry_data [ENTRIES];
  logic [AGE_W-1:0]      entry_age  [ENTRIES];
  logic [CNT_W-1:0]      occ;

  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    victim;
  logic [ENTRIES-1:0]    free_slot;
  logic                  hit;
  logic [AGE_W-1:0]      hit_age;
  logic [DATA_WIDTH-1:0] hit_data;
  logic                  full;

  lkv_cmd_t              cmd;
  logic [ENTRIES-1:0]    sel;
  logic [CNT_W-1:0]      rank;

  lkv_lookup #(
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH),
    .AGE_W      (AGE_W),
    .CNT_W      (CNT_W)
  ) u_lookup (
    .valid_i    (entry_valid),
    .key_i      (entry_key),
    .data_i     (entry_data),
    .age_i      (entry_age),
    .occ_i      (occ),
    .req_key_i  (req_key_q),
    .match_o    (match),
    .victim_o   (victim),
    .free_o     (free_slot),
    .hit_o      (hit),
    .hit_age_o  (hit_age),
    .hit_data_o (hit_data)
  );

  assign full = (CMP_W'(occ) >= cap_eff);

  // decide the store update for the request being processed
  always_comb begin
    cmd  = '0;
    sel  = match;
    rank = CNT_W'(hit_age);
    if (proc_fire) begin
      if (hit) begin
        // get or put hit: refresh recency, put also rewrites data
        cmd.touch     = 1'b1;
        cmd.load_data = is_put;
      end else if (is_put) begin
        cmd.load_key  = 1'b1;
        cmd.load_data = 1'b1;
        if (full) begin
          // replace the oldest entry in place
          sel       = victim;
          rank      = occ - CNT_W'(1);
          cmd.touch = |victim;
        end else begin
          // fill the lowest free slot
          sel       = free_slot;
          rank      = occ;
          cmd.touch = 1'b1;
          cmd.alloc = 1'b1;
        end
      end
    end
  end

  lkv_store #(
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH),
    .AGE_W      (AGE_W),
    .CNT_W      (CNT_W)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sel_i   (sel),
    .rank_i  (rank),
    .key_i   (req_key_q),
    .data_i  (req_data_q),
    .valid_o (entry_valid),
    .key_o   (entry_key),
    .data_o  (entry_data),
    .age_o   (entry_age),
    .occ_o   (occ)
  );

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (proc_fire && !is_put) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && !is_put) begin
      rsp_hit_q  <= hit;
      rsp_data_q <= hit ? hit_data : '1;
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.hit      = rsp_hit_q;
  assign rsp_o.data_out = rsp_data_q;

`ifndef SYNTH
  // occupancy counter tracks the number of valid entries
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(entry_valid) == 32'(occ))
    else $error("occupancy count differs from valid entries");

  // a key lives in at most one entry
  a_match_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("key matches several entries");

  // an insert below capacity always finds a free slot
  a_free_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && is_put && !hit && !full) |-> $onehot(free_slot))
    else $error("no free slot for insert below capacity");

  // a processed get always leaves a response
  a_get_responds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && !is_put) |=> rsp_valid_q)
    else $error("get produced no response");
`endif

endmodule

`default_nettype wire
